FILE: design/fsrm_pkg.sv
// ----------------------------------------------------------------------------
// fsrm_pkg: shared types and constants for the foveated shading rate map
// Register indexes, rate codes, datapath widths and the grader handshake.
// ----------------------------------------------------------------------------
package fsrm_pkg;

   // viewport and tile geometry
   localparam int MAX_TILES = 256;
   localparam int TILE_EDGE = 16;
   localparam int TILE_AREA = TILE_EDGE * TILE_EDGE;

   // field widths
   localparam int DIM_W   = 9;
   localparam int COORD_W = 8;
   localparam int Q16_W   = 16;
   localparam int FRAG_W  = 9;
   localparam int SUM_W   = 25;
   localparam int CSR_IDX_W = 3;

   // shared multiplier width: covers |DX|*H and R*W*H with 9-bit dims
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int OFS_W  = Q16_W + DIM_W;   // tile offset and gaze*dim

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COLS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_ROWS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAZE_X      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAZE_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FOVEAL_R    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_R       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CTR_HALF    = 3'd7;

   // modes
   localparam logic [1:0] MODE_UNIFORM = 2'd0;
   localparam logic [1:0] MODE_FIXED   = 2'd1;

   // rate codes
   localparam logic [1:0] RATE_FULL      = 2'd0;
   localparam logic [1:0] RATE_QUARTER   = 2'd1;
   localparam logic [1:0] RATE_SIXTEENTH = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [DIM_W-1:0] cols;    // clamped to MAX_TILES
      logic [DIM_W-1:0] rows;    // clamped to MAX_TILES
      logic [Q16_W-1:0] gaze_x;
      logic [Q16_W-1:0] gaze_y;
      logic [Q16_W-1:0] foveal_r;
      logic [Q16_W-1:0] mid_r;
      logic [Q16_W-1:0] ctr_half;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic ack;
   } grd_ctrl_type;

   typedef struct packed {
      logic       idle;
      logic       done;
      logic [1:0] rate;
   } grd_stat_type;

   function automatic logic [FRAG_W-1:0] frag_count(input logic [1:0] rate);
      logic [FRAG_W-1:0] f;
      case (rate)
         RATE_FULL:      f = FRAG_W'(TILE_AREA);
         RATE_QUARTER:   f = FRAG_W'(TILE_AREA >> 2);
         RATE_SIXTEENTH: f = FRAG_W'(TILE_AREA >> 4);
         default:        f = FRAG_W'(TILE_AREA >> 6);
      endcase
      return f;
   endfunction

endpackage

FILE: design/fsrm_grader.sv
// ----------------------------------------------------------------------------
// fsrm_grader: rate decision for one tile
// Small sequencer around one registered 34x34 multiplier.
// ----------------------------------------------------------------------------
module fsrm_grader (
   input  logic                         clock,
   input  logic                         reset,
   input  fsrm_pkg::cfg_type            cfg,
   input  fsrm_pkg::grd_ctrl_type       ctrl,
   input  logic [fsrm_pkg::COORD_W-1:0] tile_col,
   input  logic [fsrm_pkg::COORD_W-1:0] tile_row,
   output fsrm_pkg::grd_stat_type       stat
);

   localparam int MUL_W  = fsrm_pkg::MUL_W;
   localparam int PROD_W = fsrm_pkg::PROD_W;
   localparam int OFS_W  = fsrm_pkg::OFS_W;
   localparam int DIM_W  = fsrm_pkg::DIM_W;
   localparam int Q16_W  = fsrm_pkg::Q16_W;
   localparam int COORD_W = fsrm_pkg::COORD_W;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_GX   = 5'd1;
   localparam logic [4:0] S_GY   = 5'd2;
   localparam logic [4:0] S_DXH  = 5'd3;
   localparam logic [4:0] S_DYW  = 5'd4;
   localparam logic [4:0] S_SQA  = 5'd5;
   localparam logic [4:0] S_SQB  = 5'd6;
   localparam logic [4:0] S_RFW  = 5'd7;
   localparam logic [4:0] S_RFH  = 5'd8;
   localparam logic [4:0] S_RFSQ = 5'd9;
   localparam logic [4:0] S_CMPF = 5'd10;
   localparam logic [4:0] S_RMH  = 5'd11;
   localparam logic [4:0] S_RMSQ = 5'd12;
   localparam logic [4:0] S_CMPM = 5'd13;
   localparam logic [4:0] S_FW   = 5'd14;
   localparam logic [4:0] S_FH   = 5'd15;
   localparam logic [4:0] S_FCMP = 5'd16;
   localparam logic [4:0] S_DONE = 5'd17;

   // |tile centre - gaze*dim|, tile centre = coord*65536 + 32768
   function automatic logic [OFS_W-1:0] abs_ofs(input logic [COORD_W-1:0] coord,
                                                input logic [OFS_W-1:0]   g);
      logic [OFS_W-1:0] c;
      c = {1'b0, coord, 1'b1, {(Q16_W-1){1'b0}}};
      return (c >= g) ? (c - g) : (g - c);
   endfunction

   // signed band test: dim/2 - half <= coord < dim/2 + half
   function automatic logic in_band(input logic [COORD_W-1:0] coord,
                                    input logic [DIM_W-1:0]   dim,
                                    input logic [DIM_W-1:0]   half);
      logic signed [DIM_W+1:0] s;
      logic signed [DIM_W+1:0] lo;
      logic signed [DIM_W+1:0] hi;
      s  = $signed({3'b000, coord});
      lo = $signed({3'b000, dim[DIM_W-1:1]}) - $signed({2'b00, half});
      hi = $signed({3'b000, dim[DIM_W-1:1]}) + $signed({2'b00, half});
      return (s >= lo) && (s < hi);
   endfunction

   logic [4:0]         state_ff, state_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic [OFS_W-1:0]   dx_ff, dx_in;
   logic [OFS_W-1:0]   dy_ff, dy_in;
   logic [MUL_W-1:0]   a_ff, a_in;
   logic [PROD_W:0]    lhs_ff, lhs_in;
   logic [1:0]         rate_ff, rate_in;
   logic               inx_ff, inx_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic               rhs_hit;

   assign rhs_hit = lhs_ff < {1'b0, prod_ff};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      a_in     = a_ff;
      lhs_in   = lhs_ff;
      rate_in  = rate_ff;
      inx_in   = inx_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               x_in = tile_col;
               y_in = tile_row;
               if (cfg.mode == fsrm_pkg::MODE_UNIFORM) begin
                  rate_in  = fsrm_pkg::RATE_FULL;
                  state_in = S_DONE;
               end else if (cfg.mode == fsrm_pkg::MODE_FIXED) begin
                  state_in = S_FW;
               end else begin
                  state_in = S_GX;
               end
            end
         end
         S_GX: begin
            mul_a    = MUL_W'(cfg.gaze_x);
            mul_b    = MUL_W'(cfg.cols);
            state_in = S_GY;
         end
         S_GY: begin
            mul_a    = MUL_W'(cfg.gaze_y);
            mul_b    = MUL_W'(cfg.rows);
            dx_in    = abs_ofs(x_ff, prod_ff[OFS_W-1:0]);
            state_in = S_DXH;
         end
         S_DXH: begin
            mul_a    = MUL_W'(dx_ff);
            mul_b    = MUL_W'(cfg.rows);
            dy_in    = abs_ofs(y_ff, prod_ff[OFS_W-1:0]);
            state_in = S_DYW;
         end
         S_DYW: begin
            mul_a    = MUL_W'(dy_ff);
            mul_b    = MUL_W'(cfg.cols);
            a_in     = prod_ff[MUL_W-1:0];      // DX*H
            state_in = S_SQA;
         end
         S_SQA: begin
            mul_a    = a_ff;
            mul_b    = a_ff;
            a_in     = prod_ff[MUL_W-1:0];      // DY*W
            state_in = S_SQB;
         end
         S_SQB: begin
            mul_a    = a_ff;
            mul_b    = a_ff;
            lhs_in   = {1'b0, prod_ff};
            state_in = S_RFW;
         end
         S_RFW: begin
            mul_a    = MUL_W'(cfg.foveal_r);
            mul_b    = MUL_W'(cfg.cols);
            lhs_in   = lhs_ff + {1'b0, prod_ff};
            state_in = S_RFH;
         end
         S_RFH, S_RMH: begin
            mul_a    = MUL_W'(prod_ff[OFS_W-1:0]);
            mul_b    = MUL_W'(cfg.rows);
            state_in = (state_ff == S_RFH) ? S_RFSQ : S_RMSQ;
         end
         S_RFSQ, S_RMSQ: begin
            mul_a    = prod_ff[MUL_W-1:0];
            mul_b    = prod_ff[MUL_W-1:0];
            state_in = (state_ff == S_RFSQ) ? S_CMPF : S_CMPM;
         end
         S_CMPF: begin
            mul_a = MUL_W'(cfg.mid_r);
            mul_b = MUL_W'(cfg.cols);
            if (rhs_hit) begin
               rate_in  = fsrm_pkg::RATE_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_RMH;
            end
         end
         S_CMPM: begin
            rate_in  = rhs_hit ? fsrm_pkg::RATE_QUARTER : fsrm_pkg::RATE_SIXTEENTH;
            state_in = S_DONE;
         end
         S_FW: begin
            mul_a    = MUL_W'(cfg.cols);
            mul_b    = MUL_W'(cfg.ctr_half);
            state_in = S_FH;
         end
         S_FH: begin
            mul_a    = MUL_W'(cfg.rows);
            mul_b    = MUL_W'(cfg.ctr_half);
            inx_in   = in_band(x_ff, cfg.cols, prod_ff[OFS_W-1:Q16_W]);
            state_in = S_FCMP;
         end
         S_FCMP: begin
            rate_in  = (inx_ff && in_band(y_ff, cfg.rows, prod_ff[OFS_W-1:Q16_W]))
                       ? fsrm_pkg::RATE_FULL : fsrm_pkg::RATE_QUARTER;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ctrl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      a_ff    <= a_in;
      lhs_ff  <= lhs_in;
      rate_ff <= rate_in;
      inx_ff  <= inx_in;
      prod_ff <= mul_a * mul_b;
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);
   assign stat.rate = rate_ff;

endmodule

FILE: design/foveated_shading_rate_map.sv
// ----------------------------------------------------------------------------
// foveated_shading_rate_map: per-tile variable shading rate and frame cost
// Grades each screen tile as full, 2x2 or 4x4 rate and keeps a frame total.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one tile word (column, row, frame_start) under valid/ready.
//   rsp_* returns one word per tile: rate code, fragment cost of the tile
//   and the running frame total, saturating at 2^25-1. frame_start clears
//   the total before the tile is added.
//   csr_* writes one of eight registers per cycle; write only while idle.
// Timing:
//   One tile at a time through a shared 34x34 multiplier under a sequencer.
//   Uniform mode grades without the multiplier, fixed centre mode uses it
//   for the band test, and the gaze test needs up to 12 multiplier passes.
//   req_ready rises again the cycle after the result moves to the output
//   register, so a new tile is accepted only after the last leaves the grader.
// Reset: registers return to their defaults, frame total clears, no word
//   is pending. Stall: a word not taken holds in the output register; the
//   next tile may already be accepted and graded, then waits for the slot.
// ----------------------------------------------------------------------------
module foveated_shading_rate_map (
   input  logic                           clock,
   input  logic                           reset,
   // tile request
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [fsrm_pkg::COORD_W-1:0]   req_tile_col,
   input  logic [fsrm_pkg::COORD_W-1:0]   req_tile_row,
   input  logic                           req_frame_start,
   // rate response
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_rate_code,
   output logic [fsrm_pkg::FRAG_W-1:0]    rsp_tile_fragments,
   output logic [fsrm_pkg::SUM_W-1:0]     rsp_frame_total,
   // register writes
   input  logic                           csr_write_enable,
   input  logic [fsrm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fsrm_pkg::Q16_W-1:0]     csr_write_data
);

   localparam int DIM_W  = fsrm_pkg::DIM_W;
   localparam int Q16_W  = fsrm_pkg::Q16_W;
   localparam int SUM_W  = fsrm_pkg::SUM_W;
   localparam int FRAG_W = fsrm_pkg::FRAG_W;
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(fsrm_pkg::MAX_TILES);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]       mode_ff;
   logic [DIM_W-1:0] cols_ff;
   logic [DIM_W-1:0] rows_ff;
   logic [Q16_W-1:0] gaze_x_ff;
   logic [Q16_W-1:0] gaze_y_ff;
   logic [Q16_W-1:0] foveal_r_ff;
   logic [Q16_W-1:0] mid_r_ff;
   logic [Q16_W-1:0] ctr_half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= fsrm_pkg::MODE_UNIFORM;
         cols_ff     <= 9'd120;
         rows_ff     <= 9'd68;
         gaze_x_ff   <= 16'd32768;
         gaze_y_ff   <= 16'd32768;
         foveal_r_ff <= 16'd6554;
         mid_r_ff    <= 16'd22938;
         ctr_half_ff <= 16'd9830;
      end else if (csr_write_enable) begin
         case (csr_index)
            fsrm_pkg::CSR_MODE:      mode_ff     <= csr_write_data[1:0];
            fsrm_pkg::CSR_TILE_COLS: cols_ff     <= csr_write_data[DIM_W-1:0];
            fsrm_pkg::CSR_TILE_ROWS: rows_ff     <= csr_write_data[DIM_W-1:0];
            fsrm_pkg::CSR_GAZE_X:    gaze_x_ff   <= csr_write_data;
            fsrm_pkg::CSR_GAZE_Y:    gaze_y_ff   <= csr_write_data;
            fsrm_pkg::CSR_FOVEAL_R:  foveal_r_ff <= csr_write_data;
            fsrm_pkg::CSR_MID_R:     mid_r_ff    <= csr_write_data;
            fsrm_pkg::CSR_CTR_HALF:  ctr_half_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // viewport dims saturate at MAX_TILES before use
   fsrm_pkg::cfg_type cfg;
   always_comb begin
      cfg.mode     = mode_ff;
      cfg.cols     = (cols_ff > DIM_MAX) ? DIM_MAX : cols_ff;
      cfg.rows     = (rows_ff > DIM_MAX) ? DIM_MAX : rows_ff;
      cfg.gaze_x   = gaze_x_ff;
      cfg.gaze_y   = gaze_y_ff;
      cfg.foveal_r = foveal_r_ff;
      cfg.mid_r    = mid_r_ff;
      cfg.ctr_half = ctr_half_ff;
   end

   // ---------------------------------------------------------------------
   // grader
   // ---------------------------------------------------------------------
   fsrm_pkg::grd_ctrl_type grd_ctrl;
   fsrm_pkg::grd_stat_type grd_stat;
   logic req_fire;
   logic load;     // finished grade moves into the output slot
   logic rsp_valid_ff;

   assign req_ready      = grd_stat.idle;
   assign req_fire       = req_valid && req_ready;
   assign load           = grd_stat.done && (!rsp_valid_ff || rsp_ready);
   assign grd_ctrl.start = req_fire;
   assign grd_ctrl.ack   = load;

   fsrm_grader u_grader (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .ctrl     (grd_ctrl),
      .tile_col (req_tile_col),
      .tile_row (req_tile_row),
      .stat     (grd_stat)
   );

   // frame_start rides along with the tile being graded
   logic fs_ff;
   always_ff @(posedge clock) begin
      if (req_fire) begin
         fs_ff <= req_frame_start;
      end
   end

   // ---------------------------------------------------------------------
   // frame total and output slot
   // ---------------------------------------------------------------------
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  sum_base;
   logic [SUM_W:0]    sum_wide;
   logic [FRAG_W-1:0] frags;

   logic [1:0]        rsp_rate_code_ff;
   logic [FRAG_W-1:0] rsp_tile_fragments_ff;
   logic [SUM_W-1:0]  rsp_frame_total_ff;

   assign frags    = fsrm_pkg::frag_count(grd_stat.rate);
   assign sum_base = fs_ff ? '0 : sum_ff;
   assign sum_wide = {1'b0, sum_base} + (SUM_W + 1)'(frags);
   assign sum_in   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            sum_ff <= sum_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_rate_code_ff      <= grd_stat.rate;
         rsp_tile_fragments_ff <= frags;
         rsp_frame_total_ff    <= sum_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rate_code      = rsp_rate_code_ff;
   assign rsp_tile_fragments = rsp_tile_fragments_ff;
   assign rsp_frame_total    = rsp_frame_total_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // fragment cost always matches the reported rate
   a_frag_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_tile_fragments_ff == fsrm_pkg::frag_count(rsp_rate_code_ff))
      else $error("tile fragments do not match rate code");

   // within a frame the running total never goes down
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      (load && !fs_ff) |=> rsp_frame_total_ff >= $past(sum_ff))
      else $error("frame total decreased without frame start");

   // a finished grade waits while the output slot is blocked
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (grd_stat.done && rsp_valid_ff && !rsp_ready)
      |=> grd_stat.done && $stable(grd_stat.rate))
      else $error("grade lost while response stalled");

   // no new tile is taken while a grade is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !grd_stat.idle)
      else $error("grader idle right after accepting a tile");

endmodule
